// ===== sv/midi_note_tempo_scanner_defines.svh =====
// ----------------------------------------------------------------------------
// midi_note_tempo_scanner assertion macros
// Shared concurrent assertion forms for the note/tempo scanner.
// ----------------------------------------------------------------------------
`ifndef MIDI_NOTE_TEMPO_SCANNER_DEFINES_SVH
`define MIDI_NOTE_TEMPO_SCANNER_DEFINES_SVH

// same-cycle implication
`define MNTS_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("mnts assertion failed");

// next-cycle implication
`define MNTS_ASSERT_NXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("mnts assertion failed");

`endif

// ===== sv/mnts_pkg.sv =====
// ----------------------------------------------------------------------------
// mnts_pkg
// Types, constants and helper functions of the MIDI note/tempo scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package mnts_pkg;

   localparam int BYTE_W      = 8;
   localparam int KIND_W      = 2;
   localparam int TONE_W      = 4;
   localparam int OCT_W       = 5;
   localparam int TEMPO_W     = 26;
   localparam int DIVISOR_W   = 24;
   localparam int WIN_DEPTH   = 5;
   localparam int FILL_W      = 3;
   localparam int SKIP_W      = 2;
   localparam int MAX_RESULTS = 4;
   localparam int RES_CNT_W   = 3;

   localparam logic [BYTE_W-1:0] BYTE_ZERO     = 8'h00;
   localparam logic [BYTE_W-1:0] BYTE_NOTE_ON  = 8'h90;
   localparam logic [BYTE_W-1:0] BYTE_META     = 8'hFF;
   localparam logic [BYTE_W-1:0] BYTE_NOTE_OFF = 8'h80;
   localparam logic [BYTE_W-1:0] BYTE_TEMPO    = 8'h51;
   localparam logic [BYTE_W-1:0] KEY_IDLE      = 8'h01;

   localparam logic [TEMPO_W-1:0] TEMPO_DIVIDEND = 26'd60000000;

   localparam int KEY_DIV   = 12;
   // ceil(2^11 / 12), exact for all 8-bit keys
   localparam int KEY_RECIP = 171;
   localparam int KEY_SHIFT = 11;

   localparam logic [KIND_W-1:0] KIND_NOTE       = 2'd0;
   localparam logic [KIND_W-1:0] KIND_TEMPO      = 2'd1;
   localparam logic [KIND_W-1:0] KIND_TEMPO_ZERO = 2'd2;

   typedef struct packed {
      logic load;        // take the accepted byte
      logic eval;        // run the event scanner on window head
      logic push_tempo;  // hand the tempo result to the result stage
      logic div_start;
      logic shift;       // advance the window by one position
      logic clear;       // return the stream state to reset values
      logic finish;      // release the held result as last of run
   } ctrl_cmd_type;

   typedef struct packed {
      logic                 eos;
      logic                 fill_full;
      logic                 fill_empty;
      logic                 fill_one;
      logic                 tempo_hit;
      logic                 div_zero;
      logic                 div_busy;
      logic                 div_done;
      logic                 push_ok;
      logic                 pend_valid;
      logic [RES_CNT_W-1:0] res_count;
   } dp_stat_type;

   function automatic logic [OCT_W-1:0] key_octave(input logic [BYTE_W-1:0] key);
      logic [15:0] prod;
      prod = 16'(key) * 16'(KEY_RECIP);
      return OCT_W'(prod >> KEY_SHIFT);
   endfunction

   function automatic logic [TONE_W-1:0] key_tone(input logic [BYTE_W-1:0] key);
      logic [BYTE_W-1:0] base;
      base = BYTE_W'(BYTE_W'(key_octave(key)) * BYTE_W'(KEY_DIV));
      return TONE_W'(key - base);
   endfunction

endpackage

`default_nettype wire

// ===== sv/mnts_if.sv =====
// ----------------------------------------------------------------------------
// mnts_req_if / mnts_rsp_if
// Valid/ready channels for stream bytes and scanner results.
// ----------------------------------------------------------------------------
`default_nettype none

interface mnts_req_if;
   logic                         valid;
   logic                         ready;
   logic [mnts_pkg::BYTE_W-1:0]  data_byte;
   logic                         end_of_stream;

   modport source (output valid, data_byte, end_of_stream, input ready);
   modport sink   (input valid, data_byte, end_of_stream, output ready);
endinterface

interface mnts_rsp_if;
   logic                         valid;
   logic                         ready;
   logic [mnts_pkg::KIND_W-1:0]  result_kind;
   logic [mnts_pkg::TONE_W-1:0]  tone;
   logic [mnts_pkg::OCT_W-1:0]   octave;
   logic [mnts_pkg::TEMPO_W-1:0] tempo_bpm;
   logic                         last_of_run;

   modport source (output valid, result_kind, tone, octave, tempo_bpm, last_of_run,
                   input ready);
   modport sink   (input valid, result_kind, tone, octave, tempo_bpm, last_of_run,
                   output ready);
endinterface

`default_nettype wire

// ===== sv/mnts_div.sv =====
// ----------------------------------------------------------------------------
// mnts_div
// Restoring divider: 60000000 / divisor, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module mnts_div (
   input  wire logic                             clock,
   input  wire logic                             reset,
   input  wire logic                             start,
   input  wire logic [mnts_pkg::DIVISOR_W-1:0]   divisor,
   output logic      [mnts_pkg::TEMPO_W-1:0]     quotient,
   output logic                                  busy,
   output logic                                  done
);

   localparam int STEP_W = $clog2(mnts_pkg::TEMPO_W);

   logic [mnts_pkg::DIVISOR_W-1:0] dvs_ff, dvs_in;
   logic [mnts_pkg::DIVISOR_W-1:0] rem_ff, rem_in;
   logic [mnts_pkg::TEMPO_W-1:0]   quo_ff, quo_in;
   logic [STEP_W-1:0]              step_ff, step_in;
   logic                           busy_ff, busy_in;
   logic                           done_ff, done_in;
   logic [mnts_pkg::DIVISOR_W:0]   trial;
   logic                           fits;

   // partial remainder stays below the divisor, so the shifted value fits
   assign trial = {rem_ff, mnts_pkg::TEMPO_DIVIDEND[step_ff]};
   assign fits  = trial >= {1'b0, dvs_ff};

   always_comb begin
      dvs_in  = dvs_ff;
      rem_in  = rem_ff;
      quo_in  = quo_ff;
      step_in = step_ff;
      busy_in = busy_ff;
      done_in = done_ff;
      if (start) begin
         dvs_in  = divisor;
         rem_in  = '0;
         quo_in  = '0;
         step_in = STEP_W'(mnts_pkg::TEMPO_W - 1);
         busy_in = 1'b1;
         done_in = 1'b0;
      end else if (busy_ff) begin
         rem_in = fits ? mnts_pkg::DIVISOR_W'(trial - {1'b0, dvs_ff})
                       : mnts_pkg::DIVISOR_W'(trial);
         quo_in = {quo_ff[mnts_pkg::TEMPO_W-2:0], fits};
         if (step_ff == '0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff - 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      dvs_ff  <= dvs_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      step_ff <= step_in;
   end

   assign quotient = quo_ff;
   assign busy     = busy_ff;
   assign done     = done_ff;

endmodule

`default_nettype wire

// ===== sv/mnts_dp.sv =====
// ----------------------------------------------------------------------------
// mnts_dp
// Byte window, event scanner state, tempo divider and result staging.
// ----------------------------------------------------------------------------
`default_nettype none

module mnts_dp #(
   parameter int MAX_STREAM_BYTES = 1024
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic [mnts_pkg::BYTE_W-1:0]   req_data_byte,
   input  wire logic                          req_end_of_stream,
   input  wire mnts_pkg::ctrl_cmd_type        cmd,
   output mnts_pkg::dp_stat_type              stat,
   mnts_rsp_if.source                         rsp_bus
);

   localparam int CNT_W = $clog2(MAX_STREAM_BYTES + 1);
   localparam int WIN   = mnts_pkg::WIN_DEPTH;
   localparam logic [mnts_pkg::SKIP_W-1:0] SKIP_HEADER = 2'd3;
   localparam logic [mnts_pkg::SKIP_W-1:0] SKIP_OFF    = 2'd2;

   logic [mnts_pkg::BYTE_W-1:0]    win_ff [WIN];
   logic [mnts_pkg::BYTE_W-1:0]    win_in [WIN];
   logic [mnts_pkg::FILL_W-1:0]    fill_ff, fill_in;
   logic [CNT_W-1:0]               cnt_ff, cnt_in;
   logic [mnts_pkg::SKIP_W-1:0]    skip_ff, skip_in;
   logic [mnts_pkg::BYTE_W-1:0]    key_ff, key_in;
   logic                           eos_ff, eos_in;

   logic                           meta_hit, note_hit, off_hit, tempo_hit;
   logic [mnts_pkg::DIVISOR_W-1:0] divisor;
   logic [mnts_pkg::TEMPO_W-1:0]   quotient;
   logic                           div_busy, div_done;

   // held result and output register
   logic                           pend_valid_ff, pend_valid_in;
   logic [mnts_pkg::KIND_W-1:0]    pend_kind_ff, pend_kind_in;
   logic [mnts_pkg::TONE_W-1:0]    pend_tone_ff, pend_tone_in;
   logic [mnts_pkg::OCT_W-1:0]     pend_oct_ff, pend_oct_in;
   logic [mnts_pkg::TEMPO_W-1:0]   pend_tempo_ff, pend_tempo_in;
   logic                           out_valid_ff, out_valid_in;
   logic [mnts_pkg::KIND_W-1:0]    out_kind_ff, out_kind_in;
   logic [mnts_pkg::TONE_W-1:0]    out_tone_ff, out_tone_in;
   logic [mnts_pkg::OCT_W-1:0]     out_oct_ff, out_oct_in;
   logic [mnts_pkg::TEMPO_W-1:0]   out_tempo_ff, out_tempo_in;
   logic                           out_last_ff, out_last_in;
   logic [mnts_pkg::RES_CNT_W-1:0] res_cnt_ff, res_cnt_in;

   logic                           push_any, out_free;
   logic [mnts_pkg::KIND_W-1:0]    new_kind;
   logic [mnts_pkg::TONE_W-1:0]    new_tone;
   logic [mnts_pkg::OCT_W-1:0]     new_oct;
   logic [mnts_pkg::TEMPO_W-1:0]   new_tempo;

   // event scanner matches at window head; fill is the count of bytes present
   assign meta_hit  = (win_ff[0] == mnts_pkg::BYTE_ZERO) && (fill_ff >= 3'd2)
                      && (win_ff[1] == mnts_pkg::BYTE_META);
   assign note_hit  = (skip_ff == '0) && !meta_hit
                      && (win_ff[0] == mnts_pkg::BYTE_ZERO) && (fill_ff >= 3'd3)
                      && (win_ff[1] == mnts_pkg::BYTE_NOTE_ON);
   assign off_hit   = (win_ff[0] == mnts_pkg::BYTE_NOTE_OFF) && (fill_ff >= 3'd2)
                      && (win_ff[1] == key_ff);
   assign tempo_hit = (win_ff[0] == mnts_pkg::BYTE_TEMPO)
                      && (fill_ff == mnts_pkg::FILL_W'(WIN));
   assign divisor   = {win_ff[2], win_ff[3], win_ff[4]};

   mnts_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .divisor  (divisor),
      .quotient (quotient),
      .busy     (div_busy),
      .done     (div_done)
   );

   always_comb begin
      win_in  = win_ff;
      fill_in = fill_ff;
      cnt_in  = cnt_ff;
      skip_in = skip_ff;
      key_in  = key_ff;
      eos_in  = eos_ff;
      if (cmd.load) begin
         eos_in = req_end_of_stream;
         if ((cnt_ff < CNT_W'(MAX_STREAM_BYTES)) && (fill_ff < mnts_pkg::FILL_W'(WIN))) begin
            win_in[fill_ff] = req_data_byte;
            fill_in         = fill_ff + 1'b1;
            cnt_in          = cnt_ff + 1'b1;
         end
      end
      if (cmd.eval) begin
         if (skip_ff != '0) begin
            skip_in = skip_ff - 1'b1;
         end else if (meta_hit) begin
            skip_in = SKIP_HEADER;
         end else if (note_hit) begin
            skip_in = SKIP_HEADER;
            key_in  = win_ff[2];
         end else if (off_hit) begin
            skip_in = SKIP_OFF;
            key_in  = mnts_pkg::KEY_IDLE;
         end
      end
      if (cmd.shift) begin
         for (int i = 0; i < WIN - 1; i++) begin
            win_in[i] = win_ff[i+1];
         end
         win_in[WIN-1] = '0;
         fill_in       = fill_ff - 1'b1;
      end
      if (cmd.clear) begin
         for (int i = 0; i < WIN; i++) begin
            win_in[i] = '0;
         end
         fill_in = '0;
         cnt_in  = '0;
         skip_in = '0;
         key_in  = mnts_pkg::KEY_IDLE;
      end
   end

   assign out_free = !out_valid_ff || rsp_bus.ready;
   assign push_any = (cmd.eval && note_hit) || cmd.push_tempo;

   always_comb begin
      if (cmd.push_tempo) begin
         new_kind  = (divisor == '0) ? mnts_pkg::KIND_TEMPO_ZERO : mnts_pkg::KIND_TEMPO;
         new_tone  = '0;
         new_oct   = '0;
         new_tempo = (divisor == '0) ? '0 : quotient;
      end else begin
         new_kind  = mnts_pkg::KIND_NOTE;
         new_tone  = mnts_pkg::key_tone(win_ff[2]);
         new_oct   = mnts_pkg::key_octave(win_ff[2]);
         new_tempo = '0;
      end
   end

   // one result is held back so the final one of a run can be marked last
   always_comb begin
      pend_valid_in = pend_valid_ff;
      pend_kind_in  = pend_kind_ff;
      pend_tone_in  = pend_tone_ff;
      pend_oct_in   = pend_oct_ff;
      pend_tempo_in = pend_tempo_ff;
      out_valid_in  = out_valid_ff && !rsp_bus.ready;
      out_kind_in   = out_kind_ff;
      out_tone_in   = out_tone_ff;
      out_oct_in    = out_oct_ff;
      out_tempo_in  = out_tempo_ff;
      out_last_in   = out_last_ff;
      res_cnt_in    = res_cnt_ff;
      if (cmd.load) begin
         res_cnt_in = '0;
      end
      if ((push_any && (res_cnt_ff < mnts_pkg::RES_CNT_W'(mnts_pkg::MAX_RESULTS)))
          || (cmd.finish && pend_valid_ff)) begin
         if (pend_valid_ff) begin
            out_valid_in = 1'b1;
            out_kind_in  = pend_kind_ff;
            out_tone_in  = pend_tone_ff;
            out_oct_in   = pend_oct_ff;
            out_tempo_in = pend_tempo_ff;
            out_last_in  = cmd.finish;
         end
         if (cmd.finish) begin
            pend_valid_in = 1'b0;
         end else begin
            pend_valid_in = 1'b1;
            pend_kind_in  = new_kind;
            pend_tone_in  = new_tone;
            pend_oct_in   = new_oct;
            pend_tempo_in = new_tempo;
            res_cnt_in    = res_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < WIN; i++) begin
            win_ff[i] <= '0;
         end
         fill_ff       <= '0;
         cnt_ff        <= '0;
         skip_ff       <= '0;
         key_ff        <= mnts_pkg::KEY_IDLE;
         eos_ff        <= 1'b0;
         pend_valid_ff <= 1'b0;
         out_valid_ff  <= 1'b0;
         res_cnt_ff    <= '0;
      end else begin
         win_ff        <= win_in;
         fill_ff       <= fill_in;
         cnt_ff        <= cnt_in;
         skip_ff       <= skip_in;
         key_ff        <= key_in;
         eos_ff        <= eos_in;
         pend_valid_ff <= pend_valid_in;
         out_valid_ff  <= out_valid_in;
         res_cnt_ff    <= res_cnt_in;
      end
      pend_kind_ff  <= pend_kind_in;
      pend_tone_ff  <= pend_tone_in;
      pend_oct_ff   <= pend_oct_in;
      pend_tempo_ff <= pend_tempo_in;
      out_kind_ff   <= out_kind_in;
      out_tone_ff   <= out_tone_in;
      out_oct_ff    <= out_oct_in;
      out_tempo_ff  <= out_tempo_in;
      out_last_ff   <= out_last_in;
   end

   assign rsp_bus.valid       = out_valid_ff;
   assign rsp_bus.result_kind = out_kind_ff;
   assign rsp_bus.tone        = out_tone_ff;
   assign rsp_bus.octave      = out_oct_ff;
   assign rsp_bus.tempo_bpm   = out_tempo_ff;
   assign rsp_bus.last_of_run = out_last_ff;

   assign stat.eos        = eos_ff;
   assign stat.fill_full  = (fill_ff == mnts_pkg::FILL_W'(WIN));
   assign stat.fill_empty = (fill_ff == '0);
   assign stat.fill_one   = (fill_ff == 3'd1);
   assign stat.tempo_hit  = tempo_hit;
   assign stat.div_zero   = (divisor == '0);
   assign stat.div_busy   = div_busy;
   assign stat.div_done   = div_done;
   assign stat.push_ok    = !pend_valid_ff || out_free;
   assign stat.pend_valid = pend_valid_ff;
   assign stat.res_count  = res_cnt_ff;

endmodule

`default_nettype wire

// ===== sv/mnts_ctrl.sv =====
// ----------------------------------------------------------------------------
// mnts_ctrl
// Sequencer: takes a byte, walks the window positions, launches divisions.
// ----------------------------------------------------------------------------
`default_nettype none

module mnts_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire mnts_pkg::dp_stat_type    stat,
   output mnts_pkg::ctrl_cmd_type        cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_EVAL,
      ST_TEMPO,
      ST_DIV,
      ST_NEXT,
      ST_FINISH
   } state_type;

   state_type state_ff, state_in;
   logic      ready_ff, ready_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && ready_ff) begin
               cmd.load = 1'b1;
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (stat.eos) begin
               if (stat.fill_empty) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  state_in = ST_EVAL;
               end
            end else if (stat.fill_full) begin
               state_in = ST_EVAL;
            end else begin
               state_in = ST_FINISH;
            end
         end
         ST_EVAL: begin
            if (stat.push_ok) begin
               cmd.eval = 1'b1;
               state_in = ST_TEMPO;
            end
         end
         ST_TEMPO: begin
            if (!stat.tempo_hit) begin
               state_in = ST_NEXT;
            end else if (stat.div_zero) begin
               if (stat.push_ok) begin
                  cmd.push_tempo = 1'b1;
                  state_in       = ST_NEXT;
               end
            end else begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end
         end
         ST_DIV: begin
            if (stat.div_done && stat.push_ok) begin
               cmd.push_tempo = 1'b1;
               state_in       = ST_NEXT;
            end
         end
         ST_NEXT: begin
            // a flush walks every remaining position; a normal byte only the head
            if (stat.eos) begin
               if (stat.fill_one) begin
                  cmd.clear = 1'b1;
                  state_in  = ST_FINISH;
               end else begin
                  cmd.shift = 1'b1;
                  state_in  = ST_EVAL;
               end
            end else begin
               cmd.shift = 1'b1;
               state_in  = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (stat.push_ok) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign ready_in = (state_in == ST_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         ready_ff <= 1'b1;
      end else begin
         state_ff <= state_in;
         ready_ff <= ready_in;
      end
   end

   assign req_ready = ready_ff;

endmodule

`default_nettype wire

// ===== sv/midi_note_tempo_scanner.sv =====
// A byte is accepted only in idle. While the window fills, nothing is evaluated;
// once it is full, each byte evaluates the head position, and a tempo event with
// nonzero divisor runs a division, one quotient bit per cycle. An end-of-stream
// byte evaluates every position left in the window. A result is shown once the
// next result or the end of its run is known; a full result stage stalls.
// Synchronous reset clears the window, sequencer state and valid flags.
// ----------------------------------------------------------------------------
// midi_note_tempo_scanner
// Scans a MIDI byte stream for note-on events and tempo meta events.
// ----------------------------------------------------------------------------
`default_nettype none

`include "midi_note_tempo_scanner_defines.svh"

module midi_note_tempo_scanner #(
   parameter int MAX_STREAM_BYTES = 1024
) (
   input  wire logic     clock,
   input  wire logic     reset,
   mnts_req_if.sink      req_bus,
   mnts_rsp_if.source    rsp_bus
);

   mnts_pkg::ctrl_cmd_type ctrl_cmd;
   mnts_pkg::dp_stat_type  dp_stat;
   logic                   ctrl_ready;

   mnts_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (ctrl_ready),
      .stat      (dp_stat),
      .cmd       (ctrl_cmd)
   );

   mnts_dp #(
      .MAX_STREAM_BYTES (MAX_STREAM_BYTES)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_data_byte     (req_bus.data_byte),
      .req_end_of_stream (req_bus.end_of_stream),
      .cmd               (ctrl_cmd),
      .stat              (dp_stat),
      .rsp_bus           (rsp_bus)
   );

   assign req_bus.ready = ctrl_ready;

   `MNTS_ASSERT_IMP(a_accept_nothing_held, clock, reset, req_bus.valid && req_bus.ready, !dp_stat.pend_valid)
   `MNTS_ASSERT_IMP(a_div_start_idle, clock, reset, ctrl_cmd.div_start, !dp_stat.div_busy)
   `MNTS_ASSERT_IMP(a_result_cap, clock, reset, 1'b1, dp_stat.res_count <= 3'(mnts_pkg::MAX_RESULTS))
   `MNTS_ASSERT_NXT(a_finish_releases, clock, reset, ctrl_cmd.finish, !dp_stat.pend_valid)

endmodule

`default_nettype wire
